### rtl/digamma_trigamma_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the digamma and trigamma unit
// Short forms of the concurrent checks used in the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef DIGAMMA_TRIGAMMA_UNIT_DEFINES_SVH
`define DIGAMMA_TRIGAMMA_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTU_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("digamma_trigamma_unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DTU_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("digamma_trigamma_unit: next-cycle check failed");

`endif

### rtl/dtu_pkg.sv
// ----------------------------------------------------------------------------
// Digamma and trigamma unit package
// Sequencer states, Q32.32 constants, ln 2 as a 32-bit fraction and small helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtu_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV,
    ST_DG_SEL,
    ST_DG_TINY,
    ST_LN_NORM,
    ST_LN_SQ,
    ST_LN_UP,
    ST_LN_M0,
    ST_LN_M1,
    ST_LN_M2,
    ST_DG_R2,
    ST_DG_HORN,
    ST_DG_FIN,
    ST_TG_SEL,
    ST_TG_TINY1,
    ST_TG_TINY2,
    ST_TG_ACC,
    ST_TG_R2,
    ST_TG_HORN,
    ST_TG_FIN,
    ST_ADV,
    ST_OUT,
    ST_MQ_P0,
    ST_MQ_P1,
    ST_MQ_P2,
    ST_MQ_P3,
    ST_SQ_P0,
    ST_SQ_P1,
    ST_SQ_P2,
    ST_SQ_P3
  } state_e;

  typedef struct packed {
    logic        ovf;
    logic [63:0] sum;
  } sat_sum_t;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q = 64'h0000_0001_0000_0000;

  localparam logic [63:0] DG_LIMIT = 64'h0000_000C_0000_0000;
  localparam logic [63:0] TG_LIMIT = 64'h0000_0008_0000_0000;
  localparam logic [63:0] DG_TINY  = 64'd4294;
  localparam logic [63:0] TG_TINY  = 64'd429496;

  localparam logic signed [63:0] EULER_NEG = -64'sd2479122403;
  localparam logic signed [63:0] ZETA2     = 64'sd7064938021;
  localparam logic signed [63:0] ZETA3X2N  = -64'sd10325590174;
  localparam logic [31:0]        LN2_Q     = 32'hB172_17F8;

  localparam logic signed [63:0] DG_S3  = 64'sd357913941;
  localparam logic signed [63:0] DG_S4  = 64'sd35791394;
  localparam logic signed [63:0] DG_S5  = 64'sd17043521;
  localparam logic signed [63:0] DG_S6  = 64'sd17895697;
  localparam logic signed [63:0] DG_S7  = 64'sd32537631;
  localparam logic signed [63:0] TG_B2  = 64'sd715827883;
  localparam logic signed [63:0] TG_B4  = -64'sd143165577;
  localparam logic signed [63:0] TG_B6  = 64'sd102261126;
  localparam logic signed [63:0] TG_B8  = -64'sd143165577;
  localparam logic signed [63:0] TG_B10 = 64'sd325376310;

  localparam logic [63:0] SQ_HI_MAX = 64'd46340;

  localparam logic [2:0] DG_HORN_LAST = 3'd3;
  localparam logic [2:0] TG_HORN_LAST = 3'd4;
  localparam logic [5:0] DIV_LAST     = 6'd63;
  localparam logic [5:0] LN_SQ_LAST   = 6'd31;
  localparam logic [5:0] LN_TOP_BIT   = 6'd63;
  localparam logic [5:0] LN_INT_BIAS  = 6'd32;

  // Digamma series coefficients in Horner order after the innermost one.
  function automatic logic [63:0] dg_coef(input logic [2:0] idx);
    logic [63:0] c;
    case (idx)
      3'd0:    c = DG_S6;
      3'd1:    c = DG_S5;
      3'd2:    c = DG_S4;
      3'd3:    c = DG_S3;
      default: c = DG_S3;
    endcase
    return c;
  endfunction

  // Trigamma Bernoulli coefficients in Horner order, ending with one.
  function automatic logic [63:0] tg_coef(input logic [2:0] idx);
    logic [63:0] c;
    case (idx)
      3'd0:    c = TG_B8;
      3'd1:    c = TG_B6;
      3'd2:    c = TG_B4;
      3'd3:    c = TG_B2;
      3'd4:    c = ONE_Q;
      default: c = ONE_Q;
    endcase
    return c;
  endfunction

  // Signed 64-bit add with an overflow flag.
  function automatic sat_sum_t add_sat(input logic [63:0] a, input logic [63:0] b);
    sat_sum_t res;
    res.sum = a + b;
    res.ovf = (a[63] == b[63]) && (res.sum[63] != a[63]);
    return res;
  endfunction

endpackage

### rtl/digamma_trigamma_unit.sv
// ----------------------------------------------------------------------------
// Digamma and trigamma unit
// Iterative fixed-point evaluation of digamma and trigamma of one argument.
// ----------------------------------------------------------------------------
// A user pulses start with an unsigned Q16.16 argument while busy is low. The
// unit then works through its passes and presents digamma and trigamma in
// signed Q32.32 together with a status code for exactly one cycle, marked by
// done_o. The receiver cannot stall that beat, so it must capture the result
// ports in the cycle in which done_o is high. A zero argument goes straight to
// the result beat with both results at the most negative value and the
// singularity status. Any other argument takes one pass per reduction step,
// each of which starts with the radix-2 reciprocal divider. The number of
// passes is the count of unit steps needed to lift x to 12, plus one, so it is
// at most 13; an argument small enough for the tiny digamma form needs a single
// pass. The final pass of a larger argument adds the logarithm (a normalize
// loop and a squaring loop) and about a dozen products on the shared 32 by 32
// multiplier.
`timescale 1ns / 1ps
`include "digamma_trigamma_unit_defines.svh"

module digamma_trigamma_unit #(
  parameter int ARG_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        arg_value_i,
  output logic               done_o,
  output logic signed [63:0] digamma_value_o,
  output logic signed [63:0] trigamma_value_o,
  output logic [1:0]         status_o
);

  // The argument widens to Q32.32 by a left shift.
  localparam int ArgShift = 32 - ARG_FRAC_BITS;

  dtu_pkg::state_e state_q, state_d;
  dtu_pkg::state_e ret_q, ret_d;

  // Working argument, reciprocal and divider remainder.
  logic [63:0] x_q, x_d;
  logic [63:0] r_q, r_d;
  logic [63:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;

  // Result accumulators and flags.
  logic [63:0] dg_q, dg_d;
  logic [63:0] tg_q, tg_d;
  logic        ovf_q, ovf_d;
  logic        zero_q, zero_d;
  logic        dg_done_q, dg_done_d;
  logic        tg_done_q, tg_done_d;

  // Shared product unit operands, partial sums and result.
  logic [63:0] opa_q, opa_d;
  logic [63:0] opb_q, opb_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] mres_q, mres_d;
  logic [2:0]  hk_q, hk_d;

  // Logarithm state: mantissa, fraction bits and leading-one position.
  logic [31:0] m_q, m_d;
  logic [31:0] frac_q, frac_d;
  logic [5:0]  lp_q, lp_d;

  logic        accept;
  logic [64:0] div_sh;
  logic [64:0] div_diff;
  logic        div_ge;
  logic [63:0] mag_a;
  logic [63:0] mag_b;
  logic        mq_neg;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [32:0] ln_m2;
  logic [31:0] mq_sum;
  logic [63:0] sq_sum;
  logic        sq_hi_big;
  logic        dg_tiny;
  logic        tg_tiny;
  logic        dg_loop;
  logic        tg_loop;
  logic        zero_beat;
  logic        zero_vals;
  logic        sat_beat;

  assign accept = start && !busy;
  assign busy   = (state_q != dtu_pkg::ST_IDLE);
  assign done_o = (state_q == dtu_pkg::ST_OUT);

  // One restoring step of 2^64 / x: the remainder shifts in a zero bit.
  assign div_sh   = {rem_q, 1'b0};
  assign div_diff = div_sh - {1'b0, x_q};
  assign div_ge   = !div_diff[64];

  // The product unit works on magnitudes and restores the sign at the end.
  assign mag_a  = opa_q[63] ? (~opa_q + 64'd1) : opa_q;
  assign mag_b  = opb_q[63] ? (~opb_q + 64'd1) : opb_q;
  assign mq_neg = opa_q[63] ^ opb_q[63];
  assign mq_sum = acc_q[31:0] + prod_q[31:0];

  assign sq_sum    = acc_q + {32'b0, prod_q[63:32]};
  assign sq_hi_big = ({32'b0, r_q[63:32]} > dtu_pkg::SQ_HI_MAX);

  assign ln_m2 = prod_q[63:31];

  assign dg_tiny = (x_q <= dtu_pkg::DG_TINY);
  assign tg_tiny = (x_q <= dtu_pkg::TG_TINY);
  assign dg_loop = (x_q < dtu_pkg::DG_LIMIT);
  assign tg_loop = (x_q < dtu_pkg::TG_LIMIT);

  // Operand selection for the shared 32 by 32 multiplier.
  always_comb begin
    mul_a = 32'b0;
    mul_b = 32'b0;
    case (state_q)
      dtu_pkg::ST_MQ_P0: begin
        mul_a = mag_a[31:0];
        mul_b = mag_b[31:0];
      end
      dtu_pkg::ST_MQ_P1: begin
        mul_a = mag_a[63:32];
        mul_b = mag_b[31:0];
      end
      dtu_pkg::ST_MQ_P2: begin
        mul_a = mag_a[31:0];
        mul_b = mag_b[63:32];
      end
      dtu_pkg::ST_SQ_P0: begin
        mul_a = r_q[63:32];
        mul_b = r_q[63:32];
      end
      dtu_pkg::ST_SQ_P1: begin
        mul_a = r_q[63:32];
        mul_b = r_q[31:0];
      end
      dtu_pkg::ST_SQ_P2: begin
        mul_a = r_q[31:0];
        mul_b = r_q[31:0];
      end
      dtu_pkg::ST_LN_SQ: begin
        mul_a = m_q;
        mul_b = m_q;
      end
      dtu_pkg::ST_LN_M0: begin
        mul_a = frac_q;
        mul_b = dtu_pkg::LN2_Q;
      end
      dtu_pkg::ST_LN_M1: begin
        mul_a = {26'b0, 6'(lp_q - dtu_pkg::LN_INT_BIAS)};
        mul_b = dtu_pkg::LN2_Q;
      end
      default: begin
        mul_a = 32'b0;
        mul_b = 32'b0;
      end
    endcase
  end

  assign prod_d = {32'b0, mul_a} * {32'b0, mul_b};

  // Next state of the sequencer. Product and square calls record their return.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      dtu_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (arg_value_i == 32'b0) ? dtu_pkg::ST_OUT : dtu_pkg::ST_DIV;
        end
      end
      dtu_pkg::ST_DIV: begin
        if (cnt_q == dtu_pkg::DIV_LAST) state_d = dtu_pkg::ST_DG_SEL;
      end
      dtu_pkg::ST_DG_SEL: begin
        if (dg_done_q) begin
          state_d = dtu_pkg::ST_TG_SEL;
        end else if (dg_tiny) begin
          state_d = dtu_pkg::ST_MQ_P0;
          ret_d   = dtu_pkg::ST_DG_TINY;
        end else if (dg_loop) begin
          state_d = dtu_pkg::ST_TG_SEL;
        end else begin
          state_d = dtu_pkg::ST_LN_NORM;
        end
      end
      dtu_pkg::ST_DG_TINY: state_d = dtu_pkg::ST_TG_SEL;
      dtu_pkg::ST_LN_NORM: begin
        if (acc_q[63]) state_d = dtu_pkg::ST_LN_SQ;
      end
      dtu_pkg::ST_LN_SQ: state_d = dtu_pkg::ST_LN_UP;
      dtu_pkg::ST_LN_UP: begin
        state_d = (cnt_q == dtu_pkg::LN_SQ_LAST) ? dtu_pkg::ST_LN_M0 : dtu_pkg::ST_LN_SQ;
      end
      dtu_pkg::ST_LN_M0: state_d = dtu_pkg::ST_LN_M1;
      dtu_pkg::ST_LN_M1: state_d = dtu_pkg::ST_LN_M2;
      dtu_pkg::ST_LN_M2: begin
        state_d = dtu_pkg::ST_MQ_P0;
        ret_d   = dtu_pkg::ST_DG_R2;
      end
      dtu_pkg::ST_DG_R2: begin
        state_d = dtu_pkg::ST_MQ_P0;
        ret_d   = dtu_pkg::ST_DG_HORN;
      end
      dtu_pkg::ST_DG_HORN: begin
        state_d = dtu_pkg::ST_MQ_P0;
        ret_d   = (hk_q == dtu_pkg::DG_HORN_LAST) ? dtu_pkg::ST_DG_FIN : dtu_pkg::ST_DG_HORN;
      end
      dtu_pkg::ST_DG_FIN: state_d = dtu_pkg::ST_TG_SEL;
      dtu_pkg::ST_TG_SEL: begin
        if (tg_done_q) begin
          state_d = dtu_pkg::ST_ADV;
        end else if (tg_tiny) begin
          state_d = dtu_pkg::ST_SQ_P0;
          ret_d   = dtu_pkg::ST_TG_TINY1;
        end else if (tg_loop) begin
          state_d = dtu_pkg::ST_SQ_P0;
          ret_d   = dtu_pkg::ST_TG_ACC;
        end else begin
          state_d = dtu_pkg::ST_MQ_P0;
          ret_d   = dtu_pkg::ST_TG_R2;
        end
      end
      dtu_pkg::ST_TG_TINY1: begin
        state_d = dtu_pkg::ST_MQ_P0;
        ret_d   = dtu_pkg::ST_TG_TINY2;
      end
      dtu_pkg::ST_TG_TINY2: state_d = dtu_pkg::ST_ADV;
      dtu_pkg::ST_TG_ACC:   state_d = dtu_pkg::ST_ADV;
      dtu_pkg::ST_TG_R2: begin
        state_d = dtu_pkg::ST_MQ_P0;
        ret_d   = dtu_pkg::ST_TG_HORN;
      end
      dtu_pkg::ST_TG_HORN: begin
        state_d = dtu_pkg::ST_MQ_P0;
        ret_d   = (hk_q == dtu_pkg::TG_HORN_LAST) ? dtu_pkg::ST_TG_FIN : dtu_pkg::ST_TG_HORN;
      end
      dtu_pkg::ST_TG_FIN: state_d = dtu_pkg::ST_ADV;
      dtu_pkg::ST_ADV: begin
        state_d = (dg_done_q && tg_done_q) ? dtu_pkg::ST_OUT : dtu_pkg::ST_DIV;
      end
      dtu_pkg::ST_OUT:   state_d = dtu_pkg::ST_IDLE;
      dtu_pkg::ST_MQ_P0: state_d = dtu_pkg::ST_MQ_P1;
      dtu_pkg::ST_MQ_P1: state_d = dtu_pkg::ST_MQ_P2;
      dtu_pkg::ST_MQ_P2: state_d = dtu_pkg::ST_MQ_P3;
      dtu_pkg::ST_MQ_P3: state_d = ret_q;
      dtu_pkg::ST_SQ_P0: state_d = dtu_pkg::ST_SQ_P1;
      dtu_pkg::ST_SQ_P1: state_d = dtu_pkg::ST_SQ_P2;
      dtu_pkg::ST_SQ_P2: state_d = dtu_pkg::ST_SQ_P3;
      dtu_pkg::ST_SQ_P3: state_d = ret_q;
      default:           state_d = dtu_pkg::ST_IDLE;
    endcase
  end

  // Datapath register updates for each sequencer state.
  always_comb begin
    dtu_pkg::sat_sum_t sat;
    logic [63:0]       t;
    x_d       = x_q;
    r_d       = r_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    dg_d      = dg_q;
    tg_d      = tg_q;
    ovf_d     = ovf_q;
    zero_d    = zero_q;
    dg_done_d = dg_done_q;
    tg_done_d = tg_done_q;
    opa_d     = opa_q;
    opb_d     = opb_q;
    acc_d     = acc_q;
    mres_d    = mres_q;
    hk_d      = hk_q;
    m_d       = m_q;
    frac_d    = frac_q;
    lp_d      = lp_q;
    sat       = '0;
    t         = 64'b0;
    case (state_q)
      dtu_pkg::ST_IDLE: begin
        if (accept) begin
          ovf_d     = 1'b0;
          dg_done_d = 1'b0;
          tg_done_d = 1'b0;
          if (arg_value_i == 32'b0) begin
            zero_d = 1'b1;
            dg_d   = dtu_pkg::Q_MIN;
            tg_d   = dtu_pkg::Q_MIN;
          end else begin
            zero_d = 1'b0;
            dg_d   = 64'b0;
            tg_d   = 64'b0;
            x_d    = {32'b0, arg_value_i} << ArgShift;
            rem_d  = 64'd1;
            cnt_d  = 6'd0;
          end
        end
      end
      dtu_pkg::ST_DIV: begin
        rem_d = div_ge ? div_diff[63:0] : div_sh[63:0];
        r_d   = {r_q[62:0], div_ge};
        cnt_d = cnt_q + 6'd1;
      end
      dtu_pkg::ST_DG_SEL: begin
        if (!dg_done_q) begin
          if (dg_tiny) begin
            opa_d = dtu_pkg::ZETA2;
            opb_d = x_q;
          end else if (dg_loop) begin
            dg_d = dg_q - r_q;
          end else begin
            acc_d = x_q;
            lp_d  = dtu_pkg::LN_TOP_BIT;
          end
        end
      end
      dtu_pkg::ST_DG_TINY: begin
        dg_d      = dtu_pkg::EULER_NEG - r_q + mres_q;
        dg_done_d = 1'b1;
      end
      dtu_pkg::ST_LN_NORM: begin
        if (acc_q[63]) begin
          m_d    = acc_q[63:32];
          cnt_d  = 6'd0;
          frac_d = 32'b0;
        end else begin
          acc_d = {acc_q[62:0], 1'b0};
          lp_d  = lp_q - 6'd1;
        end
      end
      dtu_pkg::ST_LN_UP: begin
        frac_d = {frac_q[30:0], ln_m2[32]};
        m_d    = ln_m2[32] ? ln_m2[32:1] : ln_m2[31:0];
        cnt_d  = cnt_q + 6'd1;
      end
      dtu_pkg::ST_LN_M1: begin
        acc_d = {32'b0, prod_q[63:32]};
      end
      dtu_pkg::ST_LN_M2: begin
        dg_d  = dg_q + (prod_q + acc_q) - {r_q[63], r_q[63:1]};
        opa_d = r_q;
        opb_d = r_q;
      end
      dtu_pkg::ST_DG_R2: begin
        opa_d = mres_q;
        opb_d = dtu_pkg::DG_S7;
        hk_d  = 3'd0;
      end
      dtu_pkg::ST_DG_HORN: begin
        t     = dtu_pkg::dg_coef(hk_q) - mres_q;
        opb_d = t;
        hk_d  = hk_q + 3'd1;
      end
      dtu_pkg::ST_DG_FIN: begin
        dg_d      = dg_q - mres_q;
        dg_done_d = 1'b1;
      end
      dtu_pkg::ST_TG_SEL: begin
        if (!tg_done_q && !tg_tiny && !tg_loop) begin
          opa_d = r_q;
          opb_d = r_q;
        end
      end
      dtu_pkg::ST_TG_TINY1: begin
        sat   = dtu_pkg::add_sat(mres_q, dtu_pkg::ZETA2);
        tg_d  = sat.sum;
        ovf_d = ovf_q | sat.ovf;
        opa_d = dtu_pkg::ZETA3X2N;
        opb_d = x_q;
      end
      dtu_pkg::ST_TG_TINY2: begin
        sat       = dtu_pkg::add_sat(tg_q, mres_q);
        tg_d      = sat.sum;
        ovf_d     = ovf_q | sat.ovf;
        tg_done_d = 1'b1;
      end
      dtu_pkg::ST_TG_ACC: begin
        sat   = dtu_pkg::add_sat(tg_q, mres_q);
        tg_d  = sat.sum;
        ovf_d = ovf_q | sat.ovf;
      end
      dtu_pkg::ST_TG_R2: begin
        opa_d = mres_q;
        opb_d = dtu_pkg::TG_B10;
        hk_d  = 3'd0;
      end
      dtu_pkg::ST_TG_HORN: begin
        t = dtu_pkg::tg_coef(hk_q) + mres_q;
        if (hk_q == dtu_pkg::TG_HORN_LAST) begin
          // The square of the reciprocal still sits in operand A here.
          sat   = dtu_pkg::add_sat(tg_q, {opa_q[63], opa_q[63:1]});
          tg_d  = sat.sum;
          ovf_d = ovf_q | sat.ovf;
          opa_d = t;
          opb_d = r_q;
        end else begin
          opb_d = t;
          hk_d  = hk_q + 3'd1;
        end
      end
      dtu_pkg::ST_TG_FIN: begin
        sat       = dtu_pkg::add_sat(tg_q, mres_q);
        tg_d      = sat.sum;
        ovf_d     = ovf_q | sat.ovf;
        tg_done_d = 1'b1;
      end
      dtu_pkg::ST_ADV: begin
        if (!(dg_done_q && tg_done_q)) begin
          x_d   = x_q + dtu_pkg::ONE_Q;
          rem_d = 64'd1;
          cnt_d = 6'd0;
        end
      end
      dtu_pkg::ST_MQ_P1: begin
        acc_d = {32'b0, prod_q[63:32]};
      end
      dtu_pkg::ST_MQ_P2: begin
        acc_d = {32'b0, mq_sum};
      end
      dtu_pkg::ST_MQ_P3: begin
        // Only bits 63:32 of the low product word survive.
        mres_d = mq_neg ? (64'b0 - {32'b0, mq_sum}) : {32'b0, mq_sum};
      end
      dtu_pkg::ST_SQ_P1: begin
        acc_d = {prod_q[31:0], 32'b0};
      end
      dtu_pkg::ST_SQ_P2: begin
        acc_d = acc_q + {prod_q[62:0], 1'b0};
      end
      dtu_pkg::ST_SQ_P3: begin
        mres_d = sq_sum;
        if (sq_sum[63] || sq_hi_big) ovf_d = 1'b1;
      end
      default: begin
        x_d = x_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dtu_pkg::ST_IDLE;
      ret_q     <= dtu_pkg::ST_IDLE;
      dg_done_q <= 1'b0;
      tg_done_q <= 1'b0;
      ovf_q     <= 1'b0;
      zero_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      dg_done_q <= dg_done_d;
      tg_done_q <= tg_done_d;
      ovf_q     <= ovf_d;
      zero_q    <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    r_q    <= r_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    dg_q   <= dg_d;
    tg_q   <= tg_d;
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    mres_q <= mres_d;
    hk_q   <= hk_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    lp_q   <= lp_d;
  end

  // The result beat: trigamma saturates when any overflow was seen.
  assign digamma_value_o  = dg_q;
  assign trigamma_value_o = ovf_q ? dtu_pkg::Q_MAX : tg_q;
  assign status_o = zero_q ? dtu_pkg::STATUS_ZERO :
                    (ovf_q ? dtu_pkg::STATUS_SAT : dtu_pkg::STATUS_OK);

  assign zero_beat = done_o && (status_o == dtu_pkg::STATUS_ZERO);
  assign zero_vals = (digamma_value_o == dtu_pkg::Q_MIN) &&
                     (trigamma_value_o == dtu_pkg::Q_MIN);
  assign sat_beat  = done_o && (status_o == dtu_pkg::STATUS_SAT);

  `DTU_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `DTU_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `DTU_ASSERT_NOW(a_zero_result, zero_beat, zero_vals)
  `DTU_ASSERT_NOW(a_sat_result, sat_beat, trigamma_value_o == dtu_pkg::Q_MAX)

endmodule
